@@ hw/rtl/esau_pkg.sv @@
// ----------------------------------------------------------------------------
// esau_pkg
// shared types and constants of the embedding update block
// ----------------------------------------------------------------------------
package esau_pkg;

    // field widths of one transfer
    localparam int KEY_W   = 10;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int VLEN_W  = 7;
    localparam int ACC_W   = 48;
    localparam int NUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int PADDR_W = 4;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_RATE  = 2'd1;
    localparam logic [1:0] REG_INIT  = 2'd2;
    localparam logic [1:0] REG_VLEN  = 2'd3;

    // register reset values
    localparam logic              MODE_RST = 1'b0;
    localparam logic [VAL_W-1:0]  RATE_RST = 32'd167772;
    localparam logic [VAL_W-1:0]  INIT_RST = 32'd6554;
    localparam logic [VLEN_W-1:0] VLEN_RST = 7'd64;

    // update modes
    localparam logic MODE_SGD     = 1'b0;
    localparam logic MODE_ADAGRAD = 1'b1;

    // result status codes
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_LEN_ERR = 1'b1;

    // per-element data carried alongside the root and divide pipelines
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    gneg;
        logic                    err;
        logic                    last;
        logic [NUM_W-1:0]        num;
    } t_side;

endpackage

@@ hw/rtl/esau_in_if.sv @@
// ----------------------------------------------------------------------------
// esau_in_if
// element input channel: valid/ready with one element per transfer
// ----------------------------------------------------------------------------
interface esau_in_if;
    import esau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KEY_W-1:0]        key_index;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] variable_value;
    logic signed [VAL_W-1:0] gradient_value;
    logic                    last_element;

    modport source (
        output valid, key_index, position, variable_value, gradient_value, last_element,
        input  ready
    );
    modport sink (
        input  valid, key_index, position, variable_value, gradient_value, last_element,
        output ready
    );
endinterface

@@ hw/rtl/esau_out_if.sv @@
// ----------------------------------------------------------------------------
// esau_out_if
// result channel: valid/ready with one updated element per transfer
// ----------------------------------------------------------------------------
interface esau_out_if;
    import esau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] updated_value;
    logic                    end_of_vector;
    logic                    status;

    modport source (
        output valid, updated_value, end_of_vector, status,
        input  ready
    );
    modport sink (
        input  valid, updated_value, end_of_vector, status,
        output ready
    );
endinterface

@@ hw/rtl/esau_sqrt.sv @@
// ----------------------------------------------------------------------------
// esau_sqrt
// pipelined integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module esau_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  esau_pkg::t_side     i_side,
    input  logic [63:0]         i_radicand,
    output logic                o_valid,
    output esau_pkg::t_side     o_side,
    output logic [31:0]         o_root
);
    import esau_pkg::*;

    localparam int STAGES = ROOT_W / 2;

    typedef struct packed {
        logic [35:0]       rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    function automatic t_sq sq_step(input t_sq s, input logic [1:0] d);
        logic [35:0] t;
        logic [35:0] tr;
        t_sq         o;
        t  = {s.rem[33:0], d};
        tr = {2'b00, s.root, 2'b01};
        if (t >= tr) begin
            o.rem  = t - tr;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = t;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    logic        r_vld  [STAGES];
    t_sq         r_sq   [STAGES];
    logic [63:0] r_x    [STAGES];
    t_side       r_side [STAGES];

    t_sq         w_in_sq [STAGES];
    logic [63:0] w_in_x  [STAGES];
    t_sq         n_sq    [STAGES];

    always_comb begin
        w_in_sq[0] = '0;
        w_in_x[0]  = i_radicand;
        for (int k = 1; k < STAGES; k++) begin
            w_in_sq[k] = r_sq[k-1];
            w_in_x[k]  = r_x[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            n_sq[k] = sq_step(sq_step(w_in_sq[k], w_in_x[k][63:62]), w_in_x[k][61:60]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int k = 1; k < STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_sq[k] <= n_sq[k];
                r_x[k]  <= {w_in_x[k][59:0], 4'b0000};
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_root  = r_sq[STAGES-1].root;

endmodule

@@ hw/rtl/esau_div.sv @@
// ----------------------------------------------------------------------------
// esau_div
// pipelined restoring divide of the scaled step by the root, two bits per stage
// ----------------------------------------------------------------------------
module esau_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  esau_pkg::t_side     i_side,
    input  logic [31:0]         i_root,
    output logic                o_valid,
    output esau_pkg::t_side     o_side,
    output logic [31:0]         o_quot,
    output logic                o_ovf
);
    import esau_pkg::*;

    localparam int STAGES = ROOT_W / 2;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] q;
    } t_dv;

    function automatic t_dv dv_step(input t_dv s, input logic b, input logic [ROOT_W-1:0] d);
        logic [ROOT_W:0] t;
        t_dv             o;
        t = {s.rem, b};
        if (t >= {1'b0, d}) begin
            o.rem = ROOT_W'(t - {1'b0, d});
            o.q   = {s.q[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem = t[ROOT_W-1:0];
            o.q   = {s.q[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // input stage: zero root guard and quotient overflow check
    logic              r_p_vld;
    t_dv               r_p_dv;
    logic [31:0]       r_p_lo;
    logic [ROOT_W-1:0] r_p_root;
    logic              r_p_ovf;
    t_side             r_p_side;
    logic [ROOT_W-1:0] w_rootf;

    assign w_rootf = (i_root == '0) ? ROOT_W'(1) : i_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_adv) begin
            r_p_vld <= i_valid;
        end
    end

    // dividend is num >> 8, its upper 24 bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_dv   <= '{rem: {8'b0, i_side.num[63:40]}, q: '0};
            r_p_lo   <= i_side.num[39:8];
            r_p_root <= w_rootf;
            r_p_ovf  <= ({8'b0, i_side.num[63:40]} >= w_rootf);
            r_p_side <= i_side;
        end
    end

    logic              r_vld  [STAGES];
    t_dv               r_dv   [STAGES];
    logic [31:0]       r_lo   [STAGES];
    logic [ROOT_W-1:0] r_root [STAGES];
    logic              r_ovf  [STAGES];
    t_side             r_side [STAGES];

    t_dv               w_in_dv   [STAGES];
    logic [31:0]       w_in_lo   [STAGES];
    logic [ROOT_W-1:0] w_in_root [STAGES];
    t_dv               n_dv      [STAGES];

    always_comb begin
        w_in_dv[0]   = r_p_dv;
        w_in_lo[0]   = r_p_lo;
        w_in_root[0] = r_p_root;
        for (int k = 1; k < STAGES; k++) begin
            w_in_dv[k]   = r_dv[k-1];
            w_in_lo[k]   = r_lo[k-1];
            w_in_root[k] = r_root[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            n_dv[k] = dv_step(dv_step(w_in_dv[k], w_in_lo[k][31], w_in_root[k]),
                              w_in_lo[k][30], w_in_root[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[0] <= r_p_vld;
            for (int k = 1; k < STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ovf[0]  <= r_p_ovf;
            r_side[0] <= r_p_side;
            for (int k = 1; k < STAGES; k++) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                r_dv[k]   <= n_dv[k];
                r_lo[k]   <= {w_in_lo[k][29:0], 2'b00};
                r_root[k] <= w_in_root[k];
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_quot  = r_dv[STAGES-1].q;
    assign o_ovf   = r_ovf[STAGES-1];

endmodule

@@ hw/rtl/embedding_sgd_adagrad_update.sv @@
// ----------------------------------------------------------------------------
// embedding_sgd_adagrad_update
// streaming sgd / adagrad update of embedding elements, one per transfer
// ----------------------------------------------------------------------------
// throughput: one element per cycle while the output is taken and no clearing
//   pass runs; the accumulator read-modify-write is closed by forwarding from
//   the stage that writes, root and divide are pipelined
// reset: synchronous active low; registers take their reset values, then a
//   clearing pass over all NUM_KEYS*MAX_DIM entries clears the entry valid
//   bits while no element is taken (configuration writes are taken as usual)
// ----------------------------------------------------------------------------
module embedding_sgd_adagrad_update #(
    parameter int NUM_KEYS = 1024,
    parameter int MAX_DIM  = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    esau_in_if.sink                       i_in,
    esau_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esau_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import esau_pkg::*;

    localparam int ENTRY_COUNT = NUM_KEYS * MAX_DIM;
    localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int KRECIP      = (1 << 20) / NUM_KEYS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);
    localparam logic [10:0]       DIM11     = 11'(MAX_DIM);
    localparam logic signed [34:0] SAT_HI   = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_LO   = 35'sh7_8000_0000;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic              r_mode;
    logic [VAL_W-1:0]  r_rate;
    logic [VAL_W-1:0]  r_init;
    logic [VLEN_W-1:0] r_vlen;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RST;
            r_rate <= RATE_RST;
            r_init <= INIT_RST;
            r_vlen <= VLEN_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MODE: r_mode <= pwdata[0];
                REG_RATE: r_rate <= pwdata;
                REG_INIT: r_init <= pwdata;
                REG_VLEN: r_vlen <= pwdata[VLEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE: prdata = {31'b0, r_mode};
            REG_RATE: prdata = r_rate;
            REG_INIT: prdata = r_init;
            REG_VLEN: prdata = {25'b0, r_vlen};
        endcase
    end

    // ------------------------------------------------------------------
    // global advance: the whole pipe moves unless a finished result
    // sits in the output register and is not taken
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic w_adv;
    logic r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic w_in_ready;
    logic w_accept;

    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_in_ready = w_adv && !r_clr_busy;
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // valid bit clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: captured element, length check, gradient magnitude
    // ------------------------------------------------------------------
    logic                    r1_vld;
    logic [KEY_W-1:0]        r1_key;
    logic [POS_W-1:0]        r1_pos;
    logic signed [VAL_W-1:0] r1_val;
    logic signed [VAL_W-1:0] r1_grad;
    logic                    r1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_key  <= i_in.key_index;
            r1_pos  <= i_in.position;
            r1_val  <= i_in.variable_value;
            r1_grad <= i_in.gradient_value;
            r1_last <= i_in.last_element;
        end
    end

    logic [10:0]      s1_len;
    logic [10:0]      s1_pos;
    logic             s1_err;
    logic             s1_gneg;
    logic [VAL_W-1:0] s1_gmag;
    logic [30:0]      s1_kq_full;

    always_comb begin
        // length in use is vector_length capped at MAX_DIM
        s1_len  = ({4'b0, r_vlen} > DIM11) ? DIM11 : {4'b0, r_vlen};
        s1_pos  = {5'b0, r1_pos};
        // position out of range, or last mark not exactly on the final position
        s1_err  = (s1_pos >= s1_len) || (r1_last != ((s1_pos + 11'd1) == s1_len));
        s1_gneg = r1_grad[VAL_W-1];
        s1_gmag = s1_gneg ? (~r1_grad + 32'd1) : r1_grad;
        // key reduction, quotient estimate by reciprocal
        s1_kq_full = 31'(r1_key) * 31'(KRECIP);
    end

    // ------------------------------------------------------------------
    // stage 2: products, key remainder
    // ------------------------------------------------------------------
    logic                    r2_vld;
    logic [KEY_W-1:0]        r2_key;
    logic [KEY_W-1:0]        r2_keyq;
    logic [POS_W-1:0]        r2_pos;
    logic signed [VAL_W-1:0] r2_val;
    logic                    r2_gneg;
    logic                    r2_err;
    logic                    r2_last;
    logic [VAL_W-1:0]        r2_gmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_key  <= r1_key;
            r2_keyq <= s1_kq_full[29:20];
            r2_pos  <= r1_pos;
            r2_val  <= r1_val;
            r2_gneg <= s1_gneg;
            r2_err  <= s1_err;
            r2_last <= r1_last;
            r2_gmag <= s1_gmag;
        end
    end

    logic [NUM_W-1:0] s2_num;
    logic [NUM_W-1:0] s2_sq;
    logic [26:0]      s2_kp;
    logic [10:0]      s2_rem;
    logic [KEY_W-1:0] s2_keyr;

    always_comb begin
        s2_num = 64'(r2_gmag) * 64'(r_rate);
        s2_sq  = 64'(r2_gmag) * 64'(r2_gmag);
        s2_kp  = 27'(r2_keyq) * 27'(NUM_KEYS);
        // estimate is low by at most one, one correction step
        s2_rem = {1'b0, r2_key} - s2_kp[10:0];
        if ({6'b0, s2_rem} >= 17'(NUM_KEYS)) begin
            s2_keyr = KEY_W'(s2_rem - 11'(NUM_KEYS));
        end else begin
            s2_keyr = s2_rem[KEY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: accumulator address, memory read issued
    // ------------------------------------------------------------------
    logic                    r3_vld;
    logic [KEY_W-1:0]        r3_keyr;
    logic [POS_W-1:0]        r3_pos;
    logic signed [VAL_W-1:0] r3_val;
    logic                    r3_gneg;
    logic                    r3_err;
    logic                    r3_last;
    logic [NUM_W-1:0]        r3_num;
    logic [ACC_W-1:0]        r3_sq16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_keyr <= s2_keyr;
            r3_pos  <= r2_pos;
            r3_val  <= r2_val;
            r3_gneg <= r2_gneg;
            r3_err  <= r2_err;
            r3_last <= r2_last;
            r3_num  <= s2_num;
            r3_sq16 <= s2_sq[63:16];
        end
    end

    logic [26:0]       s3_addr_full;
    logic [ADDR_W-1:0] s3_addr;

    assign s3_addr_full = 27'(r3_keyr) * 27'(MAX_DIM) + 27'(r3_pos);
    assign s3_addr      = s3_addr_full[ADDR_W-1:0];

    // accumulator store: {valid, accumulator}
    logic [ACC_W:0] r_acc_mem [ENTRY_COUNT];
    logic [ACC_W:0] r_rd_word;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_word <= r_acc_mem[s3_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: accumulator update with forwarding from stage 5
    // ------------------------------------------------------------------
    logic                    r4_vld;
    logic [ADDR_W-1:0]       r4_addr;
    logic signed [VAL_W-1:0] r4_val;
    logic                    r4_gneg;
    logic                    r4_err;
    logic                    r4_last;
    logic [NUM_W-1:0]        r4_num;
    logic [ACC_W-1:0]        r4_sq16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_addr <= s3_addr;
            r4_val  <= r3_val;
            r4_gneg <= r3_gneg;
            r4_err  <= r3_err;
            r4_last <= r3_last;
            r4_num  <= r3_num;
            r4_sq16 <= r3_sq16;
        end
    end

    logic              r5_vld;
    logic              r5_wr;
    logic [ADDR_W-1:0] r5_addr;
    logic [ACC_W-1:0]  r5_acc;
    t_side             r5_side;

    logic             s4_wr;
    logic             s4_fwd;
    logic [ACC_W-1:0] s4_old;
    logic [ACC_W:0]   s4_sum;
    logic [ACC_W-1:0] s4_acc;
    logic             w_mem_we;

    always_comb begin
        s4_wr  = r4_vld && (r_mode == MODE_ADAGRAD) && !r4_err;
        // the element ahead wrote on the same edge this one read
        s4_fwd = r5_vld && r5_wr && (r5_addr == r4_addr);
        if (s4_fwd) begin
            s4_old = r5_acc;
        end else if (r_rd_word[ACC_W]) begin
            s4_old = r_rd_word[ACC_W-1:0];
        end else begin
            // first use of an entry starts from the initial value
            s4_old = {16'b0, r_init};
        end
        s4_sum = {1'b0, s4_old} + {1'b0, r4_sq16};
        s4_acc = s4_sum[ACC_W] ? '1 : s4_sum[ACC_W-1:0];
    end

    assign w_mem_we = w_adv && s4_wr;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_acc_mem[r_clr_addr] <= '0;
        end else if (w_mem_we) begin
            r_acc_mem[r4_addr] <= {1'b1, s4_acc};
        end
    end

    // ------------------------------------------------------------------
    // stage 5: updated accumulator, feeds the root pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r5_wr  <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
            r5_wr  <= s4_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_addr <= r4_addr;
            r5_acc  <= s4_acc;
            r5_side <= '{value: r4_val, gneg: r4_gneg, err: r4_err,
                         last: r4_last, num: r4_num};
        end
    end

    // ------------------------------------------------------------------
    // root of (acc << 16), then (num >> 8) / root
    // ------------------------------------------------------------------
    logic        w_sq_vld;
    t_side       w_sq_side;
    logic [31:0] w_sq_root;
    logic        w_dv_vld;
    t_side       w_dv_side;
    logic [31:0] w_dv_quot;
    logic        w_dv_ovf;

    esau_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_valid    (r5_vld),
        .i_side     (r5_side),
        .i_radicand ({r5_acc, 16'b0}),
        .o_valid    (w_sq_vld),
        .o_side     (w_sq_side),
        .o_root     (w_sq_root)
    );

    esau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sq_vld),
        .i_side  (w_sq_side),
        .i_root  (w_sq_root),
        .o_valid (w_dv_vld),
        .o_side  (w_dv_side),
        .o_quot  (w_dv_quot),
        .o_ovf   (w_dv_ovf)
    );

    // ------------------------------------------------------------------
    // final: step select, signed apply, saturation
    // ------------------------------------------------------------------
    logic [39:0]             f_sgd_step;
    logic                    f_big;
    logic [31:0]             f_step32;
    logic [32:0]             f_stepc;
    logic signed [34:0]      f_v35;
    logic signed [34:0]      f_s35;
    logic signed [34:0]      f_res35;
    logic signed [VAL_W-1:0] f_res;

    always_comb begin
        f_sgd_step = w_dv_side.num[63:24];
        if (r_mode == MODE_SGD) begin
            f_big    = |f_sgd_step[39:32];
            f_step32 = f_sgd_step[31:0];
        end else begin
            f_big    = w_dv_ovf;
            f_step32 = w_dv_quot;
        end
        // any step of 2^32 or more saturates, so clamp it there
        f_stepc = f_big ? {1'b1, 32'b0} : {1'b0, f_step32};
        f_v35   = 35'(w_dv_side.value);
        f_s35   = signed'({2'b00, f_stepc});
        f_res35 = w_dv_side.gneg ? (f_v35 + f_s35) : (f_v35 - f_s35);
        if (w_dv_side.err) begin
            f_res = w_dv_side.value;
        end else if (f_res35 > SAT_HI) begin
            f_res = 32'sh7FFF_FFFF;
        end else if (f_res35 < SAT_LO) begin
            f_res = 32'sh8000_0000;
        end else begin
            f_res = f_res35[VAL_W-1:0];
        end
    end

    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_last;
    logic                    r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_dv_vld) begin
            r_out_value  <= f_res;
            r_out_last   <= w_dv_side.last;
            r_out_status <= w_dv_side.err ? ST_LEN_ERR : ST_OK;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.updated_value = r_out_value;
    assign o_out.end_of_vector = r_out_last;
    assign o_out.status        = r_out_status;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("element taken during valid bit clearing");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r1_vld)
        else $error("accepted element missing from first stage");

    a_acc_write_adagrad_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ((r_mode == MODE_ADAGRAD) && !r_clr_busy && !r4_err))
        else $error("accumulator written outside adagrad update");

endmodule
